@@ hdl/tmw_pkg.sv @@
// ---------------------------------------------------------------------------
// Trimmed-mean window filter package
// Shared constants, register codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ---------------------------------------------------------------------------
package tmw_pkg;

  // Register widths and reset values.
  localparam int LEN_BITS   = 5;
  localparam int LIMIT_BITS = 24;
  localparam int MIN_LEN    = 3;
  localparam logic [LEN_BITS-1:0]          WINDOW_LEN_RESET  = 5'd5;
  localparam logic signed [LIMIT_BITS-1:0] UPPER_LIMIT_RESET = 24'sd1280000;

  // Configuration port geometry.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_SEL_BIT   = 2;

  // Register codes, selected by one address bit.
  typedef enum logic {
    REG_WINDOW_LEN  = 1'b0,
    REG_UPPER_LIMIT = 1'b1
  } tmw_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_TRIM,
    ST_DIV,
    ST_FINISH
  } tmw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;     // write the accepted word and advance the write index
    logic rd_clear;  // restart the window walk and the accumulators
    logic rd_step;   // read the next window entry
    logic div_load;  // trim the sum and load the divider
    logic div_step;  // one quotient bit
    logic publish;   // compare with the limit and load the output register
  } tmw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;      // window has filled since the last restart
    logic rd_last;   // the read being issued is the last window entry
    logic div_last;  // the divide step being taken is the last one
    logic out_free;  // output register can take a new word this cycle
  } tmw_status_t;

endpackage

@@ hdl/tmw_stream_if.sv @@
// ---------------------------------------------------------------------------
// Trimmed-mean window filter stream interfaces
// Valid/ready channels for the sample words going in and the result words
// coming out.
// ---------------------------------------------------------------------------
interface tmw_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface tmw_result_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          held;

  modport source (output valid, output filtered, output held, input ready);
  modport sink (input valid, input filtered, input held, output ready);
endinterface

@@ hdl/tmw_ctrl.sv @@
// ---------------------------------------------------------------------------
// Trimmed-mean window filter controller
// Sequences each word through store and, once the window is full, window walk, drain, trim, divide and publish.
// ---------------------------------------------------------------------------
module tmw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tmw_pkg::tmw_status_t status,
  output tmw_pkg::tmw_cmd_t    cmd
);
  import tmw_pkg::*;

  tmw_state_t state;
  tmw_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.full) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_TRIM;
      end
      ST_TRIM: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.store    = in_valid;
        cmd.rd_clear = in_valid;
      end
      ST_WALK: begin
        cmd.rd_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_TRIM: begin
        cmd.div_load = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.publish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/tmw_dp.sv @@
// ---------------------------------------------------------------------------
// Trimmed-mean window filter datapath
// Window memory, sum and extreme tracking, bit-serial divider, limit check
// and the output register.
// ---------------------------------------------------------------------------
module tmw_dp #(
  parameter int SAMPLE_BITS = 24,
  parameter int WINDOW_MAX  = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      restart,
  input  logic [tmw_pkg::LEN_BITS-1:0]              window_len,
  input  logic signed [tmw_pkg::LIMIT_BITS-1:0]     upper_limit,
  input  logic signed [SAMPLE_BITS-1:0]             sample,
  input  logic                                      out_ready,
  input  tmw_pkg::tmw_cmd_t                         cmd,
  output tmw_pkg::tmw_status_t                      status,
  output logic                                      out_valid,
  output logic signed [SAMPLE_BITS-1:0]             filtered,
  output logic                                      held
);
  import tmw_pkg::*;

  localparam int IDX_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W    = $clog2(WINDOW_MAX + 1);
  localparam int CLW      = (LEN_BITS > LEN_W) ? LEN_BITS : LEN_W;
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
  localparam int DCW      = $clog2(SUM_BITS);
  localparam int CMP_W    = (SUM_BITS + 1 > LIMIT_BITS) ? SUM_BITS + 1 : LIMIT_BITS;

  logic [CLW-1:0]                len_raw;
  logic [LEN_W-1:0]              eff_len;
  logic [IDX_W-1:0]              write_index;
  logic                          window_full;
  logic [IDX_W-1:0]              wr_pos;
  logic [LEN_W-1:0]              wr_pos_inc;
  logic signed [SAMPLE_BITS-1:0] window_mem [WINDOW_MAX];
  logic [IDX_W-1:0]              rd_addr;
  logic                          rd_valid;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          acc_first;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SAMPLE_BITS-1:0] hi;
  logic signed [SAMPLE_BITS-1:0] lo;
  logic signed [SUM_BITS-1:0]    trim_sum;
  logic [SUM_BITS-1:0]           trim_mag;
  logic                          neg;
  logic [SUM_BITS-1:0]           quo;
  logic [LEN_W-1:0]              rem;
  logic [LEN_W-1:0]              divisor;
  logic [DCW-1:0]                div_cnt;
  logic [LEN_W:0]                rem_shift;
  logic                          quo_bit;
  logic [LEN_W:0]                rem_next;
  logic [SUM_BITS:0]             mean_pos;
  logic signed [SUM_BITS:0]      mean_s;
  logic signed [SAMPLE_BITS-1:0] mean_out;
  logic                          hold;
  logic signed [SAMPLE_BITS-1:0] last_accepted;

  // Effective window length, clamped into the supported range.
  always_comb begin
    len_raw = CLW'(window_len);
    if (len_raw < CLW'(MIN_LEN)) begin
      eff_len = LEN_W'(MIN_LEN);
    end else if (len_raw > CLW'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = len_raw[LEN_W-1:0];
    end
  end

  // Write position; an index past the window wraps to the start.
  assign wr_pos     = (LEN_W'(write_index) >= eff_len) ? '0 : write_index;
  assign wr_pos_inc = LEN_W'(wr_pos) + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      write_index <= '0;
      window_full <= 1'b0;
    end else if (cmd.store) begin
      if (wr_pos_inc >= eff_len) begin
        write_index <= '0;
        window_full <= 1'b1;
      end else begin
        write_index <= wr_pos_inc[IDX_W-1:0];
      end
    end
  end

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      window_mem[wr_pos] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_step) begin
      rd_data <= window_mem[rd_addr];
    end
  end

  // Walk address and read-data valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr  <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_step;
      if (cmd.rd_clear) begin
        rd_addr <= '0;
      end else if (cmd.rd_step) begin
        rd_addr <= rd_addr + IDX_W'(1);
      end
    end
  end

  // Running sum, largest and smallest entry of the window.
  always_ff @(posedge clk) begin
    if (cmd.rd_clear) begin
      acc_first <= 1'b1;
    end else if (rd_valid) begin
      acc_first <= 1'b0;
      if (acc_first) begin
        sum <= SUM_BITS'(rd_data);
        hi  <= rd_data;
        lo  <= rd_data;
      end else begin
        sum <= sum + SUM_BITS'(rd_data);
        if (rd_data > hi) begin
          hi <= rd_data;
        end
        if (rd_data < lo) begin
          lo <= rd_data;
        end
      end
    end
  end

  // Drop both extremes and split into sign and magnitude.
  assign trim_sum = sum - SUM_BITS'(hi) - SUM_BITS'(lo);
  assign trim_mag = trim_sum[SUM_BITS-1] ? SUM_BITS'(-trim_sum) : SUM_BITS'(trim_sum);

  // Restoring divider, one quotient bit per step.
  assign rem_shift = {rem, quo[SUM_BITS-1]};
  assign quo_bit   = (rem_shift >= {1'b0, divisor});
  assign rem_next  = quo_bit ? (rem_shift - {1'b0, divisor}) : rem_shift;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo     <= trim_mag;
      rem     <= '0;
      neg     <= trim_sum[SUM_BITS-1];
      divisor <= eff_len - LEN_W'(2);
      div_cnt <= DCW'(SUM_BITS - 1);
    end else if (cmd.div_step) begin
      quo     <= {quo[SUM_BITS-2:0], quo_bit};
      rem     <= rem_next[LEN_W-1:0];
      div_cnt <= div_cnt - DCW'(1);
    end
  end

  // Signed mean, truncated toward zero, and the limit check.
  assign mean_pos = {1'b0, quo};
  assign mean_s   = neg ? $signed(-mean_pos) : $signed(mean_pos);
  assign mean_out = mean_s[SAMPLE_BITS-1:0];
  assign hold     = !(CMP_W'(mean_s) < CMP_W'(upper_limit));

  // Output register and last accepted mean.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_accepted <= '0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
      if (!hold) begin
        last_accepted <= mean_out;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      filtered <= hold ? last_accepted : mean_out;
      held     <= hold;
    end
  end

  // Status back to the controller.
  assign status.full     = window_full;
  assign status.rd_last  = (LEN_W'(rd_addr) == (eff_len - LEN_W'(1)));
  assign status.div_last = (div_cnt == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ hdl/trimmed_mean_window_filter.sv @@
// ---------------------------------------------------------------------------
// Trimmed-mean window filter
// Sliding window of speed samples; outputs the mean without the largest and
// smallest entry, holding the last accepted value when the limit is reached.
// ---------------------------------------------------------------------------
// Usage:
//   samples carries one signed Q15.8 word per item; results carries the
//   filtered value and the held flag. Both are valid/ready channels.
//   Each sample enters a circular window of window_len (3..WINDOW_MAX) entries.
//   The sample that completes the fill gives no result; every later sample
//   gives one result word over the window that includes it.
//   A sample that gives no result is only stored and leaves the block ready
//   for the next. A sample that gives a result passes from acceptance
//   through the walk through the window memory, one entry per cycle, the
//   trim and the one-bit-per-cycle divider to the publish of the result
//   word; no sample is taken meanwhile, and the next can be taken in the
//   same cycle that the result word appears.
//   The result sits in an output register, so a stalled receiver does not
//   stop the next sample from being accepted; the block only waits before
//   publishing if the previous result word is still held.
//   Registers (APB, 4-byte stride): window_len at 0, upper_limit at 4.
//   Writing window_len restarts the fill. Write registers only while idle.
//   Reset (synchronous, rst high) restores register defaults, empties the
//   window and clears the last accepted value to zero.
// ---------------------------------------------------------------------------
module trimmed_mean_window_filter #(
  parameter int SAMPLE_BITS = 24,
  parameter int WINDOW_MAX  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  tmw_sample_if.sink                             samples,
  tmw_result_if.source                           results,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tmw_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [tmw_pkg::APB_DATA_BITS-1:0]      pwdata,
  output logic [tmw_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                   pready
);
  import tmw_pkg::*;

  logic [LEN_BITS-1:0]          window_len;
  logic signed [LIMIT_BITS-1:0] upper_limit;
  logic                         cfg_wr;
  tmw_reg_t                     reg_sel;
  logic                         restart;
  tmw_cmd_t                     cmd;
  tmw_status_t                  status;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = tmw_reg_t'(paddr[REG_SEL_BIT]);
  assign restart = cfg_wr && (reg_sel == REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len  <= WINDOW_LEN_RESET;
      upper_limit <= UPPER_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WINDOW_LEN:  window_len  <= pwdata[LEN_BITS-1:0];
        REG_UPPER_LIMIT: upper_limit <= pwdata[LIMIT_BITS-1:0];
        default:         window_len  <= window_len;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WINDOW_LEN:  prdata = APB_DATA_BITS'(window_len);
      REG_UPPER_LIMIT: prdata = APB_DATA_BITS'($unsigned(upper_limit));
      default:         prdata = '0;
    endcase
  end

  // Controller.
  tmw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  tmw_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW_MAX  (WINDOW_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .window_len  (window_len),
    .upper_limit (upper_limit),
    .sample      (samples.sample),
    .out_ready   (results.ready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (results.valid),
    .filtered    (results.filtered),
    .held        (results.held)
  );

`ifndef NO_ASSERTIONS
  // A new result word is only ever published while the block is busy.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> !$past(samples.ready))
    else $error("result word appeared without a busy controller");

  // Accepting into a full window must start the walk.
  a_full_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready && status.full) |=> !samples.ready)
    else $error("full-window sample did not start processing");

  // Publishing loads the output register.
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> results.valid)
    else $error("published word not presented on the result channel");
`endif

endmodule
